// ===== rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the 3x3 Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W         = 8;
    localparam int ENERGY_W      = 21;   // gx^2 + gy^2 <= 2 * 1020^2
    localparam int DIM_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int DEF_MAX_WIDTH = 2048;

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [ENERGY_W-1:0]  t_energy;
    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 2'd1;

    localparam t_dim WIDTH_RST  = 12'd640;
    localparam t_dim HEIGHT_RST = 12'd480;
    localparam t_dim DIM_MIN    = 12'd3;

    localparam t_pix MAG_SAT = 8'hFF;

endpackage

// ===== rtl/sem_isqrt.sv =====
// ----------------------------------------------------------------------------
// sem_isqrt
// Iterative integer square root, one result bit per cycle, saturated to 255.
// ----------------------------------------------------------------------------
module sem_isqrt
    import sem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_energy i_energy,
    output logic    o_done,
    output t_pix    o_root
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_sat;
    logic [2:0]           r_bit;
    t_pix                 r_root;
    logic [2*PIX_W-1:0]   r_val;

    t_pix                 trial;
    logic [2*PIX_W-1:0]   trial_sq;

    assign trial    = r_root | (t_pix'(1) << r_bit);
    assign trial_sq = {{PIX_W{1'b0}}, trial} * {{PIX_W{1'b0}}, trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= |i_energy[ENERGY_W-1:2*PIX_W];
            r_val  <= i_energy[2*PIX_W-1:0];
            r_root <= '0;
            r_bit  <= 3'd7;
        end else if (r_busy) begin
            if (trial_sq <= r_val) begin
                r_root <= trial;
            end
            r_bit <= r_bit - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_sat ? MAG_SAT : r_root;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("root unit restarted while busy");

    a_done_after_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_busy) && $past(r_bit) == 3'd0)
        else $error("root done without finishing all bits");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("root unit busy and done together");

endmodule

// ===== rtl/sobel_edge_magnitude_3x3_top.sv =====
// Interior pixel: line store access (S_RD), gradients (S_GRAD), squares (S_SQ), the bit-serial
// square root unit (S_ROOT), result beat (S_OUT); next pixel taken only once the result is loaded.
// Border pixel: no result, next pixel taken after the S_RD state (line store read + write).
// The line store is a registered-read RAM; each pixel does read, then modify/write.
// Synchronous reset clears counters, state and output valid; registers go to 640x480.
// Line store contents are not cleared; rows 0 and 1 mask what they read.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_top
// Streaming 3x3 Sobel gradient magnitude with two line stores in one RAM.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_top
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_pix     i_pixel,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pix     o_magnitude,
    output logic     o_last_of_frame,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  t_dim     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WC_W  = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;

    t_dim                  r_img_width;
    t_dim                  r_img_height;
    logic [COL_W-1:0]      r_col;
    t_dim                  r_row;

    // per-pixel context captured on the input beat
    t_pix                  r_pix;
    logic [COL_W-1:0]      r_cur_col;
    logic                  r_row0;
    logic                  r_row1;
    logic                  r_emit;
    logic                  r_last;

    logic [2*PIX_W-1:0]    r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]    r_rd_data;

    t_pix                  r_win [3][3];
    logic signed [10:0]    r_gx;
    logic signed [10:0]    r_gy;

    logic                  r_out_valid;
    t_pix                  r_magnitude;
    logic                  r_out_last;

    logic                  in_beat;
    logic                  cfg_hit;
    logic [WC_W-1:0]       width_ext;
    logic [WC_W-1:0]       w_eff;
    logic [COL_W-1:0]      w_last;
    t_dim                  h_eff;
    t_dim                  h_last;
    logic [2*PIX_W-1:0]    entry;
    logic signed [21:0]    sq_x;
    logic signed [21:0]    sq_y;
    t_energy               energy;
    logic                  root_start;
    logic                  root_done;
    t_pix                  root_val;
    logic                  out_load;

    function automatic logic [9:0] sum121(input t_pix a, input t_pix b, input t_pix c);
        sum121 = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    assign in_beat     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid &&
                         (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT);

    // effective frame size
    assign width_ext = WC_W'(r_img_width);
    always_comb begin
        if (width_ext < WC_W'(DIM_MIN)) begin
            w_eff = WC_W'(DIM_MIN);
        end else if (width_ext > WC_W'(MAX_WIDTH)) begin
            w_eff = WC_W'(MAX_WIDTH);
        end else begin
            w_eff = width_ext;
        end
    end
    assign w_last = COL_W'(w_eff - WC_W'(1));
    assign h_eff  = (r_img_height < DIM_MIN) ? DIM_MIN : r_img_height;
    assign h_last = h_eff - 12'd1;

    // configuration registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= WIDTH_RST;
            r_img_height <= HEIGHT_RST;
            r_col        <= '0;
            r_row        <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_img_width <= i_cfg_data;
            end else begin
                r_img_height <= i_cfg_data;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (in_beat) begin
            if (r_col == w_last) begin
                r_col <= '0;
                r_row <= (r_row == h_last) ? '0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pix     <= i_pixel;
            r_cur_col <= r_col;
            r_row0    <= (r_row == 12'd0);
            r_row1    <= (r_row == 12'd1);
            r_emit    <= (r_row >= 12'd2) && (r_col >= COL_W'(2));
            r_last    <= (r_row == h_last) && (r_col == w_last);
        end
    end

    // line store: low byte one line up, high byte two lines up
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_line_mem[r_cur_col] <= {entry[PIX_W-1:0], r_pix};
        end
        if (in_beat) begin
            r_rd_data <= r_line_mem[r_col];
        end
    end

    // row 0 sees no valid data from the store, row 1 only the line one up
    always_comb begin
        if (r_row0) begin
            entry = '0;
        end else if (r_row1) begin
            entry = {{PIX_W{1'b0}}, r_rd_data[PIX_W-1:0]};
        end else begin
            entry = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= entry[2*PIX_W-1:PIX_W];
            r_win[1][2] <= entry[PIX_W-1:0];
            r_win[2][2] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GRAD) begin
            r_gx <= $signed({1'b0, sum121(r_win[0][2], r_win[1][2], r_win[2][2])})
                  - $signed({1'b0, sum121(r_win[0][0], r_win[1][0], r_win[2][0])});
            r_gy <= $signed({1'b0, sum121(r_win[2][0], r_win[2][1], r_win[2][2])})
                  - $signed({1'b0, sum121(r_win[0][0], r_win[0][1], r_win[0][2])});
        end
    end

    assign sq_x       = 22'(r_gx) * 22'(r_gx);
    assign sq_y       = 22'(r_gy) * 22'(r_gy);
    assign energy     = {1'b0, sq_x[19:0]} + {1'b0, sq_y[19:0]};
    assign root_start = (r_state == S_SQ);

    sem_isqrt u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (root_start),
        .i_energy (energy),
        .o_done   (root_done),
        .o_root   (root_val)
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_beat) n_state = S_RD;
            S_RD:   n_state = r_emit ? S_GRAD : S_IDLE;
            S_GRAD: n_state = S_SQ;
            S_SQ:   n_state = S_ROOT;
            S_ROOT: if (root_done) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_magnitude <= root_val;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_magnitude     = r_magnitude;
    assign o_last_of_frame = r_out_last;

    a_beat_reads_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_state == S_RD)
        else $error("input beat not followed by line store access");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_last)
        else $error("column counter beyond line end");

    a_out_from_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> $past(r_state) == S_ROOT || $past(r_state) == S_OUT)
        else $error("result stage entered without a root");

    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result beat raised outside result stage");

endmodule
